FILE: rtl/udiv_pkg.sv
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared constants and types for the pipelined unsigned divider.
// ----------------------------------------------------------------------------
package udiv_pkg;

  localparam int IO_WIDTH = 64;

  typedef struct packed {
    logic valid;
    logic zero_div;
  } ctl_t;

endpackage

FILE: rtl/udiv_step.sv
// ----------------------------------------------------------------------------
// udiv_step
// One restoring-division step: shift in one dividend bit, trial subtract,
// record one quotient bit, register the result.
// ----------------------------------------------------------------------------
module udiv_step #(
  parameter int WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  udiv_pkg::ctl_t    ctl_in,
  input  logic [WIDTH-1:0]  rem_in,
  input  logic [WIDTH-1:0]  work_in,
  input  logic [WIDTH-1:0]  den_in,
  output udiv_pkg::ctl_t    ctl_out,
  output logic [WIDTH-1:0]  rem_out,
  output logic [WIDTH-1:0]  work_out,
  output logic [WIDTH-1:0]  den_out
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             fits;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] work_next;

  // work holds unused dividend bits on top, quotient bits entering at bottom
  always_comb begin
    shifted   = {rem_in, work_in[WIDTH-1]};
    diff      = {1'b0, shifted} - {2'b00, den_in};
    fits      = ~diff[WIDTH+1];
    rem_next  = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    work_next = {work_in[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_out  <= rem_next;
    work_out <= work_next;
    den_out  <= den_in;
  end

endmodule

FILE: rtl/uint64_restoring_divider.sv
// ----------------------------------------------------------------------------
// uint64_restoring_divider
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
// Takes one request per clock: a request is accepted whenever start is high,
// and busy is always low. The quotient of each request appears on quotient
// with a one-cycle done strobe, in request order; the receiver cannot stall
// it. Each request passes through the chain of DATA_WIDTH subtract-and-compare
// stages, one per quotient bit, and then the output register. Only the low
// DATA_WIDTH bits of each operand are used and the upper quotient bits read
// zero. A zero divisor gives quotient zero.
module uint64_restoring_divider #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [udiv_pkg::IO_WIDTH-1:0] dividend,
  input  logic [udiv_pkg::IO_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [udiv_pkg::IO_WIDTH-1:0] quotient
);

  udiv_pkg::ctl_t         ctl  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0]  rem  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0]  work [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0]  den  [0:DATA_WIDTH];

  logic [udiv_pkg::IO_WIDTH-1:0] quotient_next;

  assign busy = 1'b0;

  always_comb begin
    ctl[0].valid    = start;
    ctl[0].zero_div = (divisor[DATA_WIDTH-1:0] == '0);
    rem[0]          = '0;
    work[0]         = dividend[DATA_WIDTH-1:0];
    den[0]          = divisor[DATA_WIDTH-1:0];
  end

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    udiv_step #(
      .WIDTH(DATA_WIDTH)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl[i]),
      .rem_in  (rem[i]),
      .work_in (work[i]),
      .den_in  (den[i]),
      .ctl_out (ctl[i+1]),
      .rem_out (rem[i+1]),
      .work_out(work[i+1]),
      .den_out (den[i+1])
    );
  end

  assign quotient_next = ctl[DATA_WIDTH].zero_div ? '0
                       : udiv_pkg::IO_WIDTH'(work[DATA_WIDTH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[DATA_WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    quotient <= quotient_next;
  end

endmodule

FILE: rtl/udiv_chk.sv
// ----------------------------------------------------------------------------
// udiv_chk
// Port-level checks for the pipelined divider, bound to the top level.
// ----------------------------------------------------------------------------
module udiv_chk #(
  parameter int DATA_WIDTH = 64
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [udiv_pkg::IO_WIDTH-1:0] dividend,
  input logic [udiv_pkg::IO_WIDTH-1:0] divisor,
  input logic                          done,
  input logic [udiv_pkg::IO_WIDTH-1:0] quotient
);

  localparam int LAT = DATA_WIDTH + 1;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  a_request_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without request");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    start && (divisor[DATA_WIDTH-1:0] == '0) |-> ##LAT (quotient == '0))
    else $error("zero divisor gave nonzero quotient");

  a_unit_div: assert property (@(posedge clk) disable iff (rst)
    start && (divisor[DATA_WIDTH-1:0] == DATA_WIDTH'(1)) |->
      ##LAT (quotient[DATA_WIDTH-1:0] == $past(dividend[DATA_WIDTH-1:0], LAT)))
    else $error("divide by one mismatch");

endmodule

bind uint64_restoring_divider udiv_chk #(.DATA_WIDTH(DATA_WIDTH)) u_udiv_chk (.*);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for uint64_restoring_divider. Operand pairs are queued
// up front and issued one request per start/busy handshake, with random idle
// cycles and a drain pause. Every accepted request is run through a local
// bit-serial divide, and each done strobe is compared in order against it.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH = 64;
  localparam int W          = udiv_pkg::IO_WIDTH;
  localparam int RAND_REQS  = 1650;
  localparam int CALM_LO    = 700;
  localparam int CALM_HI    = 1000;

  typedef struct {
    logic [W-1:0] num;
    logic [W-1:0] den;
    bit           drain;
  } div_req_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] dividend = '0;
  logic [W-1:0] divisor = '0;
  logic         done;
  logic [W-1:0] quotient;

  div_req_t     req_q[$];
  logic [W-1:0] quo_q[$];
  bit           took_req = 1'b0;
  int           sent_cnt = 0;
  int           taken_cnt = 0;
  int           mismatch_cnt = 0;
  int           total_reqs;

  uint64_restoring_divider #(.DATA_WIDTH(DATA_WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (done),
    .quotient (quotient)
  );

  always #6 clk = ~clk;

  // restoring divide with a remainder one bit wider than the operands
  function automatic logic [W-1:0] udiv_quotient(logic [W-1:0] num, logic [W-1:0] den);
    logic [W-1:0] mask;
    logic [W:0]   part_rem;
    logic [W-1:0] q;
    mask = {W{1'b1}} >> (W - DATA_WIDTH);
    num  = num & mask;
    den  = den & mask;
    part_rem = '0;
    q = '0;
    if (den == '0) return '0;
    for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
      part_rem = {part_rem[W-1:0], num[i]};
      if (part_rem >= {1'b0, den}) begin
        part_rem = part_rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q & mask;
  endfunction

  function automatic logic [W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [W-1:0] rand_bits(int n);
    return rand64() >> (W - n);
  endfunction

  function automatic void add_req(logic [W-1:0] num, logic [W-1:0] den, bit drain = 1'b0);
    div_req_t r;
    r.num   = num;
    r.den   = den;
    r.drain = drain;
    req_q.push_back(r);
  endfunction

  // driver: new request or idle at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_req) begin
      if (req_q.size() == 0 || (req_q[0].drain && quo_q.size() != 0) ||
          (!(sent_cnt >= CALM_LO && sent_cnt < CALM_HI) && $urandom_range(99) < 22)) begin
        start <= 1'b0;
      end else begin
        dividend <= req_q[0].num;
        divisor  <= req_q[0].den;
        start    <= 1'b1;
        void'(req_q.pop_front());
        sent_cnt++;
      end
    end
  end

  // monitor: log accepted requests, check each done strobe
  always @(posedge clk) begin : mon
    logic [W-1:0] want;
    if (rst) begin
      took_req <= 1'b0;
    end else begin
      took_req <= start && !busy;
      if (start && !busy) begin
        quo_q.push_back(udiv_quotient(dividend, divisor));
        taken_cnt++;
      end
      if (done) begin
        if (quo_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: quotient=%h", quotient);
        end else begin
          want = quo_q.pop_front();
          if (quotient !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("quotient mismatch: expected %h, got %h", want, quotient);
          end
        end
      end
    end
  end

  initial begin
    logic [W-1:0] a;
    logic [W-1:0] b;
    int           kind;
    logic [W-1:0] top;
    top = {1'b1, {(W-1){1'b0}}};

    add_req('0, '0);
    add_req('1, '0);
    add_req('1, 64'd1);
    add_req('1, '1);
    add_req('0, '1);
    add_req(64'd1, 64'd1);
    add_req(top, top);
    add_req('1, top);
    add_req('1, top + 64'd1);
    add_req(top - 64'd1, top);
    add_req('1, 64'd2);
    add_req('1, '1 - 64'd1);
    add_req('1 - 64'd1, '1);
    add_req(64'd7, 64'd9);
    add_req(64'd100, 64'd7);
    add_req(64'h5555_5555_5555_5555, 64'h0000_0000_0000_0003);
    add_req(64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0001_0000_0000);
    add_req(top, 64'd1);
    add_req(64'd12345, 64'd0);
    add_req(64'hFFFF_FFFF, 64'h1_0000_0000);
    add_req(64'h1_0000_0000, 64'hFFFF_FFFF);
    add_req(64'hDEAD_BEEF_CAFE_F00D, 64'hDEAD_BEEF_CAFE_F00D);

    for (int n = 0; n < RAND_REQS; n++) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2: begin
          a = rand64();
          b = rand64();
        end
        3, 4: begin
          a = rand64();
          b = rand_bits($urandom_range(1, 32));
        end
        5: begin
          a = rand64();
          b = rand64() | top;
        end
        6: begin
          a = rand_bits($urandom_range(1, 64));
          b = rand_bits($urandom_range(1, 64));
        end
        7: begin
          b = rand_bits($urandom_range(1, 32));
          a = b * rand_bits($urandom_range(1, 32));
        end
        8: begin
          a = rand64();
          b = '0;
        end
        default: begin
          a = rand64();
          b = a + rand_bits($urandom_range(1, 4)) - 64'd2;
        end
      endcase
      add_req(a, b, n == 0 || n == 500 || n == 1200 || $urandom_range(199) == 0);
    end
    total_reqs = req_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_cnt < total_reqs) @(posedge clk);
    while (quo_q.size() != 0) @(posedge clk);
    repeat (DATA_WIDTH + 20) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: uint64_restoring_divider.f
rtl/udiv_pkg.sv
rtl/udiv_step.sv
rtl/uint64_restoring_divider.sv
rtl/udiv_chk.sv
verif/tb.sv
